/* rtl/rawt_pkg.sv */
// Shared types and constants of the receive ack window tracker.
`default_nettype none
package rawt_pkg;
   localparam int SEQ_W   = 8;
   localparam int NODE_W  = 5;
   localparam int CAUSE_W = 2;

   localparam logic [CAUSE_W-1:0] CAUSE_NONE     = 2'd0;
   localparam logic [CAUSE_W-1:0] CAUSE_OLD_DUP  = 2'd1;
   localparam logic [CAUSE_W-1:0] CAUSE_QUEUED   = 2'd2;
   localparam logic [CAUSE_W-1:0] CAUSE_FULL     = 2'd3;

   // Outcome of one wraparound sequence comparison of a against b.
   typedef struct packed {
      logic older;       // a is strictly older than b
      logic not_newer;   // a is older than or equal to b
   } cmp_res_type;

   // Next sequence number; zero is skipped.
   function automatic logic [SEQ_W-1:0] seq_next(input logic [SEQ_W-1:0] v);
      logic [SEQ_W-1:0] n;
      n = v + SEQ_W'(1);
      if (n == '0) begin
         n = SEQ_W'(1);
      end
      return n;
   endfunction
endpackage
`default_nettype wire

/* rtl/rawt_ram.sv */
// Generic single-port RAM with registered read data.
`default_nettype none
module rawt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                                    clock,
   input  wire logic                                    we,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
   input  wire logic [WIDTH-1:0]                        wdata,
   output      logic [WIDTH-1:0]                        rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rd_data_ff <= mem[addr];
   end

   assign rdata = rd_data_ff;
endmodule
`default_nettype wire

/* rtl/rawt_seqcmp.sv */
// Shared wraparound sequence comparator used by the remote, old-ack and scan steps of the sequencer.
`default_nettype none
module rawt_seqcmp (
   input  wire logic [rawt_pkg::SEQ_W-1:0] a,
   input  wire logic [rawt_pkg::SEQ_W-1:0] b,
   output      rawt_pkg::cmp_res_type      res
);
   logic signed [rawt_pkg::SEQ_W:0] diff;

   always_comb begin
      diff = $signed({1'b0, a}) - $signed({1'b0, b});
      // A difference of 127 or more, or below -128, is taken as wrapped.
      res.older = ((diff < 0) && (diff >= -9'sd128)) || (diff >= 9'sd127);
      res.not_newer = res.older || (diff == 0);
   end
endmodule
`default_nettype wire

/* rtl/receive_ack_window_tracker.sv */
// Top level of the receive ack window tracker: sequencer, node state and ack ring.
// How to use this block:
// The req channel takes one beat per received packet: the remote node, the
// sequence number to acknowledge (zero for an unreliable packet) and the
// partner's returned cumulative ack (zero for none). Each request beat yields
// exactly one rsp beat with the accept flag, the discard cause, the node's
// cumulative ack, and the partner ack with a flag telling whether it moved.
// Requests are worked one at a time. Each first has its node index reduced
// modulo NODES, then loads the node state and updates the partner ack.
// An unreliable packet ends there and an old duplicate after its age check.
// Any other packet then searches the ring for a duplicate, one entry at a time.
// An in-order ack then runs passes of the advance scan over the ring, and
// another pass follows each pass in which the ack moved. A full ring whose
// entries are released one per pass needs up to about 64 passes.
// The result sits in an output register; the next request is taken while it
// waits, and the sequencer only holds in its final step if a second result
// is ready before the first was taken. A stalled rsp side thus stalls req.
// Reset clears the sequencer, the output valid flag and one valid bit per node;
// a node never written reads as all zero. Ring entries need no clearing since
// only entries between tail and head are ever read, and all were written.
`default_nettype none
module receive_ack_window_tracker #(
   parameter int NODES      = 32,
   parameter int RING_DEPTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // [4:0] node_index, [12:5] seq_ack, [20:13] ack_return, [23:21] zero
   input  wire logic [23:0] req_tdata,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // [0] packet_good, [2:1] discard_cause, [10:3] cumulative_ack,
   // [11] remote_advanced, [19:12] remote_ack, [23:20] zero
   output      logic [23:0] rsp_tdata
);
   localparam int SW     = rawt_pkg::SEQ_W;
   localparam int PW     = $clog2(RING_DEPTH);
   localparam int NAW    = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int QDEPTH = NODES * RING_DEPTH;
   localparam int QAW    = $clog2(QDEPTH);
   localparam int NSW    = 2 * SW + 2 * PW;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_REDUCE  = 4'd1;
   localparam logic [3:0] S_LOAD    = 4'd2;
   localparam logic [3:0] S_FETCH   = 4'd3;
   localparam logic [3:0] S_REMOTE  = 4'd4;
   localparam logic [3:0] S_OLD     = 4'd5;
   localparam logic [3:0] S_DUP_RD  = 4'd6;
   localparam logic [3:0] S_DUP_CK  = 4'd7;
   localparam logic [3:0] S_DECIDE  = 4'd8;
   localparam logic [3:0] S_SCAN_RD = 4'd9;
   localparam logic [3:0] S_SCAN_CK = 4'd10;
   localparam logic [3:0] S_DONE    = 4'd11;

   function automatic logic [PW-1:0] ring_inc(input logic [PW-1:0] p);
      return (p == PW'(RING_DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   function automatic logic [PW-1:0] ring_dec(input logic [PW-1:0] p);
      return (p == '0) ? PW'(RING_DEPTH - 1) : p - PW'(1);
   endfunction

   logic [3:0]                    state_ff, state_in;
   logic [rawt_pkg::NODE_W-1:0]   node_ff, node_in;
   logic [SW-1:0]                 ack_ff, ack_in;
   logic [SW-1:0]                 aret_ff, aret_in;
   logic [SW-1:0]                 first_ff, first_in;
   logic [SW-1:0]                 remote_ff, remote_in;
   logic [SW-1:0]                 nf_ff, nf_in;
   logic [PW-1:0]                 head_ff, head_in;
   logic [PW-1:0]                 tail_ff, tail_in;
   logic [PW-1:0]                 hm1_ff, hm1_in;
   logic [PW-1:0]                 idx_ff, idx_in;
   logic                          change_ff, change_in;
   logic                          adv_ff, adv_in;
   logic [rawt_pkg::CAUSE_W-1:0]  cause_ff, cause_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [23:0]                   rsp_data_ff, rsp_data_in;
   logic [NODES-1:0]              nvalid_ff, nvalid_in;

   logic [NAW-1:0]                node_idx;
   logic                          node_we;
   logic [NSW-1:0]                node_wdata, node_rdata;
   logic                          q_we;
   logic [QAW-1:0]                q_addr;
   logic [SW-1:0]                 q_rdata;
   logic [SW-1:0]                 cmp_a, cmp_b;
   rawt_pkg::cmp_res_type         cmp_res;
   logic                          done_go;
   logic [SW-1:0]                 next_first;
   logic [PW-1:0]                 next_head;
   logic                          scan_change;

   assign node_idx   = NAW'(node_ff);
   assign node_wdata = {first_ff, remote_ff, head_ff, tail_ff};
   assign done_go    = !rsp_valid_ff || rsp_tready;
   assign node_we    = (state_ff == S_DONE) && done_go;
   assign q_we       = (state_ff == S_DECIDE) && (ack_ff == rawt_pkg::seq_next(first_ff)) ?
                       1'b0 : (state_ff == S_DECIDE) && (ring_inc(head_ff) != tail_ff);
   assign q_addr     = QAW'(node_idx) * QAW'(RING_DEPTH) +
                       QAW'((state_ff == S_DECIDE) ? head_ff : idx_ff);

   rawt_ram #(.WIDTH(NSW), .DEPTH(NODES)) u_node_ram (
      .clock (clock),
      .we    (node_we),
      .addr  (node_idx),
      .wdata (node_wdata),
      .rdata (node_rdata)
   );

   rawt_ram #(.WIDTH(SW), .DEPTH(QDEPTH)) u_ring_ram (
      .clock (clock),
      .we    (q_we),
      .addr  (q_addr),
      .wdata (ack_ff),
      .rdata (q_rdata)
   );

   // The one comparator is shared across the remote, old-ack and scan steps.
   always_comb begin
      case (state_ff)
         S_REMOTE: begin
            cmp_a = remote_ff;
            cmp_b = aret_ff;
         end
         S_SCAN_CK: begin
            cmp_a = q_rdata;
            cmp_b = nf_ff;
         end
         default: begin
            cmp_a = ack_ff;
            cmp_b = first_ff;
         end
      endcase
   end

   rawt_seqcmp u_cmp (
      .a   (cmp_a),
      .b   (cmp_b),
      .res (cmp_res)
   );

   always_comb begin
      state_in     = state_ff;
      node_in      = node_ff;
      ack_in       = ack_ff;
      aret_in      = aret_ff;
      first_in     = first_ff;
      remote_in    = remote_ff;
      nf_in        = nf_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      hm1_in       = hm1_ff;
      idx_in       = idx_ff;
      change_in    = change_ff;
      adv_in       = adv_ff;
      cause_in     = cause_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      nvalid_in    = nvalid_ff;
      next_first   = rawt_pkg::seq_next(first_ff);
      next_head    = ring_inc(head_ff);
      scan_change  = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               node_in  = req_tdata[4:0];
               ack_in   = req_tdata[12:5];
               aret_in  = req_tdata[20:13];
               adv_in   = 1'b0;
               cause_in = rawt_pkg::CAUSE_NONE;
               state_in = S_REDUCE;
            end
         end
         S_REDUCE: begin
            // Node index modulo NODES by repeated subtraction.
            if ({4'b0, node_ff} >= 9'(NODES)) begin
               node_in = node_ff - rawt_pkg::NODE_W'(NODES);
            end else begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            state_in = S_FETCH;
         end
         S_FETCH: begin
            if (nvalid_ff[node_idx]) begin
               tail_in   = node_rdata[PW-1:0];
               head_in   = node_rdata[2*PW-1:PW];
               remote_in = node_rdata[2*PW+SW-1:2*PW];
               first_in  = node_rdata[NSW-1:2*PW+SW];
            end else begin
               tail_in   = '0;
               head_in   = '0;
               remote_in = '0;
               first_in  = '0;
            end
            state_in = S_REMOTE;
         end
         S_REMOTE: begin
            if ((aret_ff != '0) && cmp_res.older) begin
               remote_in = aret_ff;
               adv_in    = 1'b1;
            end
            state_in = (ack_ff == '0) ? S_DONE : S_OLD;
         end
         S_OLD: begin
            if (cmp_res.not_newer) begin
               cause_in = rawt_pkg::CAUSE_OLD_DUP;
               state_in = S_DONE;
            end else begin
               idx_in   = tail_ff;
               state_in = S_DUP_RD;
            end
         end
         S_DUP_RD: begin
            state_in = (idx_ff == head_ff) ? S_DECIDE : S_DUP_CK;
         end
         S_DUP_CK: begin
            if (q_rdata == ack_ff) begin
               cause_in = rawt_pkg::CAUSE_QUEUED;
               state_in = S_DONE;
            end else begin
               idx_in   = ring_inc(idx_ff);
               state_in = S_DUP_RD;
            end
         end
         S_DECIDE: begin
            if (ack_ff == next_first) begin
               first_in  = next_first;
               nf_in     = rawt_pkg::seq_next(next_first);
               hm1_in    = ring_dec(head_ff);
               change_in = 1'b0;
               idx_in    = tail_ff;
               state_in  = S_SCAN_RD;
            end else if (next_head != tail_ff) begin
               head_in  = next_head;
               state_in = S_DONE;
            end else begin
               cause_in = rawt_pkg::CAUSE_FULL;
               state_in = S_DONE;
            end
         end
         S_SCAN_RD: begin
            if (idx_ff == head_ff) begin
               // End of a pass; another pass runs if the ack moved.
               if (change_ff) begin
                  change_in = 1'b0;
                  idx_in    = tail_ff;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               state_in = S_SCAN_CK;
            end
         end
         S_SCAN_CK: begin
            state_in = S_SCAN_RD;
            idx_in   = ring_inc(idx_ff);
            if (cmp_res.not_newer) begin
               if (q_rdata == nf_ff) begin
                  first_in    = nf_ff;
                  nf_in       = rawt_pkg::seq_next(nf_ff);
                  change_in   = 1'b1;
                  scan_change = 1'b1;
               end
               if (idx_ff == tail_ff) begin
                  tail_in = ring_inc(idx_ff);
               end else if (idx_ff == hm1_ff) begin
                  // A stale entry at the head end shrinks the ring and
                  // ends this pass.
                  head_in = hm1_ff;
                  hm1_in  = ring_dec(hm1_ff);
                  if (change_ff || scan_change) begin
                     change_in = 1'b0;
                     idx_in    = tail_ff;
                  end else begin
                     state_in = S_DONE;
                  end
               end
            end
         end
         S_DONE: begin
            if (done_go) begin
               nvalid_in[node_idx] = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0, remote_ff, adv_ff, first_ff, cause_ff,
                               cause_ff == rawt_pkg::CAUSE_NONE};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         nvalid_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         nvalid_ff    <= nvalid_in;
      end
      node_ff     <= node_in;
      ack_ff      <= ack_in;
      aret_ff     <= aret_in;
      first_ff    <= first_in;
      remote_ff   <= remote_in;
      nf_ff       <= nf_in;
      head_ff     <= head_in;
      tail_ff     <= tail_in;
      hm1_ff      <= hm1_in;
      idx_ff      <= idx_in;
      change_ff   <= change_in;
      adv_ff      <= adv_in;
      cause_ff    <= cause_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_REDUCE))
      else $error("accepted request did not start the sequencer");

   a_node_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD) |-> ({4'b0, node_ff} < 9'(NODES)))
      else $error("node index not reduced before lookup");

   a_good_matches_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] == (rsp_tdata[2:1] == rawt_pkg::CAUSE_NONE)))
      else $error("accept flag disagrees with discard cause");

   a_ring_not_full: assert property (@(posedge clock) disable iff (reset)
      q_we |=> (head_ff != tail_ff))
      else $error("enqueue left the ring looking empty");
endmodule
`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for the receive ack window tracker: predicts every response beat.
`timescale 1ns / 100ps
`default_nettype none

// Scoreboard: keeps a software copy of the per-node window state and the queue of
// responses still owed by the block.
class ack_window_board;
   localparam int NNODES = 32;
   localparam int RDEPTH = 64;

   logic [7:0] cum_ack [NNODES];
   logic [7:0] partner_ack [NNODES];
   int unsigned head [NNODES];
   int unsigned tail [NNODES];
   logic [7:0] ring [NNODES][RDEPTH];
   logic [19:0] owed_rsp [$];
   int mismatches;
   int checked;
   int cause_seen [4];
   int advanced_seen;

   function new();
      for (int n = 0; n < NNODES; n++) begin
         cum_ack[n] = 0;
         partner_ack[n] = 0;
         head[n] = 0;
         tail[n] = 0;
         for (int k = 0; k < RDEPTH; k++) ring[n][k] = 0;
      end
      mismatches = 0;
      checked = 0;
      advanced_seen = 0;
      for (int k = 0; k < 4; k++) cause_seen[k] = 0;
   endfunction

   // Wraparound distance of a from b; negative means a is older.
   function int seq_dist(logic [7:0] a, logic [7:0] b);
      int d;
      d = int'(a) - int'(b);
      if (d >= 127 || d < -128) return -d;
      return d;
   endfunction

   function logic [7:0] bump(logic [7:0] v);
      logic [7:0] n;
      n = v + 8'd1;
      return (n == 0) ? 8'd1 : n;
   endfunction

   // Apply one accepted packet to the model and queue the response it owes.
   function void note_packet(logic [23:0] beat);
      int unsigned nd, i, hm1, nh;
      logic [7:0] sq, ar, nf;
      logic good, adv, change, cut;
      logic [1:0] cause;
      nd = beat[4:0] % NNODES;
      sq = beat[12:5];
      ar = beat[20:13];
      good = 1;
      cause = rawt_pkg::CAUSE_NONE;
      adv = 0;
      if (ar != 0 && seq_dist(partner_ack[nd], ar) < 0) begin
         partner_ack[nd] = ar;
         adv = 1;
      end
      if (sq != 0) begin
         if (seq_dist(sq, cum_ack[nd]) <= 0) begin
            good = 0;
            cause = rawt_pkg::CAUSE_OLD_DUP;
         end else begin
            for (i = tail[nd]; i != head[nd]; i = (i + 1) % RDEPTH) begin
               if (ring[nd][i] == sq) begin
                  good = 0;
                  cause = rawt_pkg::CAUSE_QUEUED;
                  break;
               end
            end
         end
         if (good) begin
            nf = bump(cum_ack[nd]);
            if (sq == nf) begin
               // In-order arrival: advance, then sweep the ring until nothing moves.
               cum_ack[nd] = nf;
               nf = bump(nf);
               hm1 = (head[nd] + RDEPTH - 1) % RDEPTH;
               change = 1;
               while (change) begin
                  change = 0;
                  i = tail[nd];
                  while (i != head[nd]) begin
                     cut = 0;
                     if (seq_dist(ring[nd][i], nf) <= 0) begin
                        if (ring[nd][i] == nf) begin
                           cum_ack[nd] = nf;
                           nf = bump(nf);
                           change = 1;
                        end
                        if (i == tail[nd]) begin
                           ring[nd][i] = 0;
                           tail[nd] = (i + 1) % RDEPTH;
                        end else if (i == hm1) begin
                           ring[nd][hm1] = 0;
                           head[nd] = hm1;
                           hm1 = (hm1 + RDEPTH - 1) % RDEPTH;
                           cut = 1;
                        end
                     end
                     if (cut) break;
                     i = (i + 1) % RDEPTH;
                  end
               end
            end else begin
               nh = (head[nd] + 1) % RDEPTH;
               if (nh != tail[nd]) begin
                  ring[nd][head[nd]] = sq;
                  head[nd] = nh;
               end else begin
                  good = 0;
                  cause = rawt_pkg::CAUSE_FULL;
               end
            end
         end
      end
      owed_rsp.push_back({partner_ack[nd], adv, cum_ack[nd], cause, good});
   endfunction

   // Compare one response beat with the oldest owed response.
   function void check_rsp(logic [23:0] beat);
      logic [19:0] exp_rsp;
      checked++;
      if (owed_rsp.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected response beat %h", beat);
         return;
      end
      exp_rsp = owed_rsp.pop_front();
      cause_seen[exp_rsp[2:1]]++;
      if (exp_rsp[11]) advanced_seen++;
      if (beat[19:0] !== exp_rsp || beat[23:20] !== 4'h0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("response mismatch: good %b/%b cause %0d/%0d cum %0d/%0d adv %b/%b rem %0d/%0d",
                     exp_rsp[0], beat[0], exp_rsp[2:1], beat[2:1], exp_rsp[10:3],
                     beat[10:3], exp_rsp[11], beat[11], exp_rsp[19:12], beat[19:12]);
      end
   endfunction
endclass

module tb_top;
   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   // [4:0] node_index, [12:5] seq_ack, [20:13] ack_return, [23:21] zero
   logic [23:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   // [0] packet_good, [2:1] discard_cause, [10:3] cumulative_ack,
   // [11] remote_advanced, [19:12] remote_ack, [23:20] zero
   logic [23:0] rsp_tdata;

   // Idle percentages, changed per phase by the stimulus process.
   int send_idle_pct;
   int recv_idle_pct;
   int unsigned cycle_count;
   int sent;
   ack_window_board board;

   // The limit allows for worst-case packets plus stalls over the whole run.
   localparam int unsigned CYCLE_LIMIT = 50_000_000;

   receive_ack_window_tracker uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // The receiver side stalls at random; responses are checked on handshake edges.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) board.check_rsp(rsp_tdata);
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Timeout watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Send one packet beat, idling first at random, and wait for its acceptance.
   task automatic send_packet(input logic [4:0] nd, input logic [7:0] sq,
                              input logic [7:0] ar);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {3'b000, ar, sq, nd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_packet({3'b000, ar, sq, nd});
      sent++;
      // Valid stays high into the next call; it is lowered only by an idle or the end.
   endtask

   // A well-formed burst on one node: near-window acks around its current state,
   // shuffled so that some arrive out of order and get queued.
   task automatic node_burst(input int len);
      logic [4:0] nd;
      logic [7:0] base, sq, ar;
      nd = $urandom_range(31);
      base = board.cum_ack[nd % 32];
      for (int k = 0; k < len; k++) begin
         sq = base + 8'($urandom_range(12)) - 8'd2;
         if ($urandom_range(9) == 0) sq = 0;
         ar = ($urandom_range(3) == 0) ? 8'd0
              : board.partner_ack[nd % 32] + 8'($urandom_range(6)) - 8'd1;
         send_packet(nd, sq, ar);
      end
   endtask

   task automatic random_phase(input int count);
      int done;
      done = 0;
      while (done < count) begin
         if ($urandom_range(9) < 8) begin
            node_burst(8);
            done += 8;
         end else begin
            send_packet(5'($urandom), 8'($urandom), 8'($urandom));
            done++;
         end
      end
   endtask

   initial begin
      logic [7:0] v;
      board = new();
      reset = 1;
      req_tvalid = 0;
      req_tdata = 0;
      cycle_count = 0;
      sent = 0;
      send_idle_pct = 23;
      recv_idle_pct = 76;
      repeat (5) @(posedge clock);
      reset <= 0;

      // Directed part: unreliable packet, partner ack extremes, old duplicate,
      // queued duplicate, in-order advance through the queue, wrap past zero.
      send_packet(5'd0, 8'd0, 8'd0);
      send_packet(5'd31, 8'd0, 8'd255);
      send_packet(5'd31, 8'd0, 8'd100);
      send_packet(5'd1, 8'd3, 8'd1);
      send_packet(5'd1, 8'd3, 8'd0);
      send_packet(5'd1, 8'd4, 8'd2);
      send_packet(5'd1, 8'd1, 8'd0);
      send_packet(5'd1, 8'd2, 8'd2);
      send_packet(5'd1, 8'd2, 8'd0);
      send_packet(5'd2, 8'd255, 8'd0);
      send_packet(5'd2, 8'd128, 8'd0);
      send_packet(5'd3, 8'd9, 8'd0);
      send_packet(5'd3, 8'd5, 8'd0);
      send_packet(5'd3, 8'd1, 8'd0);
      // Fill node 4's ring to the brim so the next out-of-order ack is dropped.
      for (int k = 0; k < 64; k++) begin
         v = 8'(k + 3);
         send_packet(5'd4, v, 8'($urandom));
      end
      send_packet(5'd4, 8'd1, 8'd0);
      send_packet(5'd4, 8'd2, 8'd0);

      // Three idling phases, then drain.
      random_phase(500);
      send_idle_pct = 76;
      recv_idle_pct = 23;
      random_phase(500);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(480);
      req_tvalid <= 0;

      while (board.owed_rsp.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);

      $display("%0d packets sent, %0d responses checked", sent, board.checked);
      $display("causes none/old/queued/full: %0d/%0d/%0d/%0d, partner advances %0d",
               board.cause_seen[0], board.cause_seen[1], board.cause_seen[2],
               board.cause_seen[3], board.advanced_seen);
      if (board.mismatches == 0 && board.owed_rsp.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches", board.mismatches);
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
